// ----- src/bsrf_pkg.sv -----
// ----------------------------------------------------------------------------
// bsrf_pkg: shared types and constants for the bitmap store
// Field widths, opcodes, sequencer states and the control/status bundles
// passed between the sequencer and the shared word unit.
// ----------------------------------------------------------------------------
package bsrf_pkg;

  // fixed field widths
  localparam int OP_W  = 2;
  localparam int POS_W = 11;
  localparam int END_W = 12;
  localparam int CFG_W = 7;

  // defaults for the top-level parameters
  localparam int WORD_BITS_DEF = 32;
  localparam int NUM_WORDS_DEF = 64;

  // capacity in words after reset
  localparam int CAP_RESET = 64;

  // request opcodes
  typedef enum logic [OP_W-1:0] {
    OP_GET  = 2'd0,
    OP_SET  = 2'd1,
    OP_CLR  = 2'd2,
    OP_FILL = 2'd3
  } bsrf_op_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_BASE,
    S_WALK,
    S_MERGE,
    S_GBIT,
    S_DONE
  } bsrf_state_t;

  // commands to the shared word unit
  typedef struct packed {
    logic split;  // word index of position via reciprocal multiply
    logic base;   // bit base of that word, load word address
    logic step;   // advance to the next word
  } bsrf_ucmd_t;

  // status from the shared word unit
  typedef struct packed {
    logic full;   // mask covers the whole word
    logic more;   // range continues past the current word
  } bsrf_ustat_t;

endpackage

// ----- src/bsrf_req_if.sv -----
// ----------------------------------------------------------------------------
// bsrf_req_if: request channel
// Valid/ready channel carrying one bitmap operation.
// ----------------------------------------------------------------------------
interface bsrf_req_if;
  import bsrf_pkg::*;

  logic              valid;
  logic              ready;
  bsrf_op_t          op;
  logic [POS_W-1:0]  position;
  logic [END_W-1:0]  range_end;
  logic              fill_value;

  modport source (output valid, op, position, range_end, fill_value, input ready);
  modport sink   (input valid, op, position, range_end, fill_value, output ready);
endinterface

// ----- src/bsrf_rsp_if.sv -----
// ----------------------------------------------------------------------------
// bsrf_rsp_if: result channel
// Valid/ready channel carrying the read bit and the bounds flag.
// ----------------------------------------------------------------------------
interface bsrf_rsp_if;
  logic valid;
  logic ready;
  logic bit_value;
  logic out_of_range;

  modport source (output valid, bit_value, out_of_range, input ready);
  modport sink   (input valid, bit_value, out_of_range, output ready);
endinterface

// ----- src/bsrf_ram.sv -----
// ----------------------------------------------------------------------------
// bsrf_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bsrf_ram #(
  parameter  int WIDTH  = 32,
  parameter  int DEPTH  = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- src/bsrf_unit.sv -----
// ----------------------------------------------------------------------------
// bsrf_unit: shared word unit
// Splits a bit position into a word index, tracks the bit base and word
// address of the current word, and builds edge masks and merged words.
// ----------------------------------------------------------------------------
module bsrf_unit #(
  parameter  int WORD_BITS = bsrf_pkg::WORD_BITS_DEF,
  parameter  int NUM_WORDS = bsrf_pkg::NUM_WORDS_DEF,
  localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
  input  logic                        clk,
  input  bsrf_pkg::bsrf_ucmd_t        ucmd,
  input  logic [bsrf_pkg::POS_W-1:0]  pos,
  input  logic [bsrf_pkg::END_W-1:0]  rng_end,
  input  logic                        fill_val,
  input  logic [WORD_BITS-1:0]        rd_data,
  output logic [ADDR_W-1:0]           addr,
  output logic [WORD_BITS-1:0]        wr_data,
  output logic                        bit_value,
  output bsrf_pkg::bsrf_ustat_t       ustat
);
  import bsrf_pkg::*;

  // reciprocal of the word width, exact for every position value
  localparam int SPLIT_SH = POS_W + $clog2(WORD_BITS);
  localparam int RECIP    = ((1 << SPLIT_SH) + WORD_BITS - 1) / WORD_BITS;
  localparam int PROD_W   = SPLIT_SH + POS_W;
  localparam int BASE_W   = END_W + 1;
  localparam int SH_W     = $clog2(WORD_BITS + 1);
  localparam int BI_W     = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

  localparam logic [BASE_W-1:0]    WB   = BASE_W'(WORD_BITS);
  localparam logic [WORD_BITS-1:0] ONES = '1;

  logic [POS_W-1:0]     q_r;
  logic [BASE_W-1:0]    base_r;
  logic [ADDR_W-1:0]    addr_r;
  logic [PROD_W-1:0]    prod;
  logic [BASE_W-1:0]    pos_x;
  logic [BASE_W-1:0]    end_x;
  logic [BASE_W-1:0]    next_base;
  logic [SH_W-1:0]      lo;
  logic [SH_W-1:0]      hi;
  logic [WORD_BITS-1:0] mask;
  logic [BI_W-1:0]      bit_idx;

  // word index by multiply with the reciprocal
  assign prod = PROD_W'(pos) * PROD_W'(RECIP);

  // index, base and address registers
  always_ff @(posedge clk) begin
    if (ucmd.split) begin
      q_r <= prod[SPLIT_SH +: POS_W];
    end
    if (ucmd.base) begin
      base_r <= BASE_W'(q_r) * WB;
      addr_r <= ADDR_W'(q_r);
    end else if (ucmd.step) begin
      base_r <= next_base;
      addr_r <= addr_r + ADDR_W'(1);
    end
  end

  assign pos_x     = BASE_W'(pos);
  assign end_x     = BASE_W'(rng_end);
  assign next_base = base_r + WB;

  // edge offsets within the current word
  always_comb begin
    lo = (pos_x > base_r) ? SH_W'(pos_x - base_r) : '0;
    hi = (end_x < next_base) ? SH_W'(end_x - base_r) : SH_W'(WORD_BITS);
  end

  // mask of bits lo up to hi-1
  assign mask = ~(ONES << hi) & (ONES << lo);

  assign wr_data = fill_val ? (rd_data | mask) : (rd_data & ~mask);

  // single bit pick for get
  assign bit_idx   = BI_W'(pos_x - base_r);
  assign bit_value = rd_data[bit_idx];

  assign addr       = addr_r;
  assign ustat.full = &mask;
  assign ustat.more = next_base < end_x;

endmodule

// ----- src/bsrf_seq.sv -----
// ----------------------------------------------------------------------------
// bsrf_seq: request sequencer
// Clears the store after reset, checks bounds, walks the words of a request
// through the shared unit and the RAM, and holds the result register.
// ----------------------------------------------------------------------------
module bsrf_seq #(
  parameter  int WORD_BITS = bsrf_pkg::WORD_BITS_DEF,
  parameter  int NUM_WORDS = bsrf_pkg::NUM_WORDS_DEF,
  parameter  int CAP_W     = bsrf_pkg::CFG_W + $clog2(bsrf_pkg::WORD_BITS_DEF + 1),
  localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  bsrf_req_if.sink                    in_ch,
  bsrf_rsp_if.source                  out_ch,
  input  logic [CAP_W-1:0]            cap_bits,
  output bsrf_pkg::bsrf_ucmd_t        ucmd,
  input  bsrf_pkg::bsrf_ustat_t       ustat,
  input  logic [ADDR_W-1:0]           u_addr,
  input  logic [WORD_BITS-1:0]        u_wr_data,
  input  logic                        u_bit,
  output logic [bsrf_pkg::POS_W-1:0]  pos,
  output logic [bsrf_pkg::END_W-1:0]  rng_end,
  output logic                        fill_val,
  output logic                        ram_we,
  output logic [ADDR_W-1:0]           ram_waddr,
  output logic [WORD_BITS-1:0]        ram_wdata,
  output logic                        ram_re,
  output logic [ADDR_W-1:0]           ram_raddr
);
  import bsrf_pkg::*;

  localparam int CMP_W = (CAP_W > END_W) ? CAP_W : END_W;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_WORDS - 1);

  bsrf_state_t      state_r, state_nxt;
  bsrf_op_t         op_r, op_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [END_W-1:0] end_r, end_nxt;
  logic             fv_r, fv_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic             res_bit_r, res_bit_nxt;
  logic             res_oor_r, res_oor_nxt;
  logic             out_valid_r;
  logic             out_bit_r;
  logic             out_oor_r;
  logic             in_ready;
  logic             out_load;
  logic [CMP_W-1:0] cap_x, pos_x, end_x;

  assign cap_x = CMP_W'(cap_bits);
  assign pos_x = CMP_W'(pos_r);
  assign end_x = CMP_W'(end_r);

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  // request and pending result registers
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    pos_r     <= pos_nxt;
    end_r     <= end_nxt;
    fv_r      <= fv_nxt;
    res_bit_r <= res_bit_nxt;
    res_oor_r <= res_oor_nxt;
  end

  // next state and outputs
  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    pos_nxt     = pos_r;
    end_nxt     = end_r;
    fv_nxt      = fv_r;
    clr_nxt     = clr_r;
    res_bit_nxt = res_bit_r;
    res_oor_nxt = res_oor_r;
    ucmd        = '0;
    ram_we      = 1'b0;
    ram_waddr   = u_addr;
    ram_wdata   = u_wr_data;
    ram_re      = 1'b0;
    ram_raddr   = u_addr;
    in_ready    = 1'b0;
    out_load    = 1'b0;

    unique case (state_r)
      // clearing sweep after reset
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + ADDR_W'(1);
        if (clr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end

      // take a request; single-bit writes become one-bit ranges
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          op_nxt  = in_ch.op;
          pos_nxt = in_ch.position;
          case (in_ch.op) inside
            OP_SET, OP_CLR: begin
              end_nxt = END_W'(in_ch.position) + END_W'(1);
              fv_nxt  = (in_ch.op == OP_SET);
            end
            default: begin
              end_nxt = in_ch.range_end;
              fv_nxt  = in_ch.fill_value;
            end
          endcase
          state_nxt = S_CHECK;
        end
      end

      // bounds check, word index split
      S_CHECK: begin
        ucmd.split  = 1'b1;
        res_bit_nxt = 1'b0;
        res_oor_nxt = 1'b0;
        case (op_r) inside
          OP_GET: begin
            state_nxt = (pos_x < cap_x) ? S_BASE : S_DONE;
          end
          OP_SET, OP_CLR: begin
            if (pos_x < cap_x) begin
              state_nxt = S_BASE;
            end else begin
              res_oor_nxt = 1'b1;
              state_nxt   = S_DONE;
            end
          end
          default: begin
            if (pos_x > end_x || end_x > cap_x) begin
              res_oor_nxt = 1'b1;
              state_nxt   = S_DONE;
            end else if (pos_x == end_x) begin
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_BASE;
            end
          end
        endcase
      end

      // word base and address
      S_BASE: begin
        ucmd.base = 1'b1;
        state_nxt = S_WALK;
      end

      // read for get or edge word, direct write for whole words
      S_WALK: begin
        if (op_r == OP_GET) begin
          ram_re    = 1'b1;
          state_nxt = S_GBIT;
        end else if (ustat.full) begin
          ram_we    = 1'b1;
          ucmd.step = 1'b1;
          state_nxt = ustat.more ? S_WALK : S_DONE;
        end else begin
          ram_re    = 1'b1;
          state_nxt = S_MERGE;
        end
      end

      // write back an edge word
      S_MERGE: begin
        ram_we    = 1'b1;
        ucmd.step = 1'b1;
        state_nxt = ustat.more ? S_WALK : S_DONE;
      end

      // pick the bit for get
      S_GBIT: begin
        res_bit_nxt = u_bit;
        state_nxt   = S_DONE;
      end

      // hand the result to the output register
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_bit_r <= res_bit_r;
      out_oor_r <= res_oor_r;
    end
  end

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.bit_value    = out_bit_r;
  assign out_ch.out_of_range = out_oor_r;

  assign pos      = pos_r;
  assign rng_end  = end_r;
  assign fill_val = fv_r;

  // a request always goes to the bounds check next
  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ready && in_ch.valid) |=> (state_r == S_CHECK))
    else $error("accepted request did not enter bounds check");

  // the store is written only by the sweep or the walk
  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CLEAR || state_r == S_WALK || state_r == S_MERGE))
    else $error("store written outside clear or walk");

  // an edge-word merge always follows its read
  a_merge_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MERGE) |-> ($past(state_r) == S_WALK && $past(ram_re)))
    else $error("merge without preceding read");

  // a held result is never overwritten
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !out_load)
    else $error("pending result overwritten");

  // a get never flags bounds, a write never returns a bit
  a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_bit_r && out_oor_r))
    else $error("result carries both bit and bounds flag");

endmodule

// ----- src/bitmap_store_with_range_fill_core.sv -----
// Single-bit requests go through check, base and walk, then a bit pick or a merge,
// before the core is ready again. A fill reads then merges each edge word on the one
// RAM port pair and writes whole words inside the range directly; rejected or empty
// requests skip the walk. One request is in flight at a time; the result register
// frees the input side. After reset the store is swept to zero, one word a cycle,
// before the first request is taken; capacity resets to 64 words, or NUM_WORDS if fewer.
// ----------------------------------------------------------------------------
// bitmap_store_with_range_fill_core: bitmap store with range fill
// Word-organised bitmap with get, set, clear and masked range fill requests,
// bounded by a programmable capacity in words.
// ----------------------------------------------------------------------------
module bitmap_store_with_range_fill_core #(
  parameter int WORD_BITS = bsrf_pkg::WORD_BITS_DEF,
  parameter int NUM_WORDS = bsrf_pkg::NUM_WORDS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  bsrf_req_if.sink                    in_ch,
  bsrf_rsp_if.source                  out_ch,
  input  logic                        cfg_wr_en,
  input  logic [bsrf_pkg::CFG_W-1:0]  cfg_wr_data
);
  import bsrf_pkg::*;

  localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int CAP_W     = CFG_W + $clog2(WORD_BITS + 1);
  localparam int RST_WORDS = (CAP_RESET > NUM_WORDS) ? NUM_WORDS : CAP_RESET;
  localparam logic [CAP_W-1:0] CAP_RST_BITS = CAP_W'(RST_WORDS * WORD_BITS);

  logic [CAP_W-1:0]     cap_bits_r, cap_bits_nxt;
  logic [CFG_W-1:0]     cap_words;
  bsrf_ucmd_t           ucmd;
  bsrf_ustat_t          ustat;
  logic [ADDR_W-1:0]    u_addr;
  logic [WORD_BITS-1:0] u_wr_data;
  logic                 u_bit;
  logic [POS_W-1:0]     pos;
  logic [END_W-1:0]     rng_end;
  logic                 fill_val;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  // capacity in bits, clamped to the store
  always_comb begin
    cap_words    = (32'(cfg_wr_data) > 32'(NUM_WORDS)) ? CFG_W'(NUM_WORDS) : cfg_wr_data;
    cap_bits_nxt = CAP_W'(cap_words) * CAP_W'(WORD_BITS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_bits_r <= CAP_RST_BITS;
    end else if (cfg_wr_en) begin
      cap_bits_r <= cap_bits_nxt;
    end
  end

  // sequencer
  bsrf_seq #(
    .WORD_BITS (WORD_BITS),
    .NUM_WORDS (NUM_WORDS),
    .CAP_W     (CAP_W)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cap_bits  (cap_bits_r),
    .ucmd      (ucmd),
    .ustat     (ustat),
    .u_addr    (u_addr),
    .u_wr_data (u_wr_data),
    .u_bit     (u_bit),
    .pos       (pos),
    .rng_end   (rng_end),
    .fill_val  (fill_val),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr)
  );

  // shared word unit
  bsrf_unit #(
    .WORD_BITS (WORD_BITS),
    .NUM_WORDS (NUM_WORDS)
  ) u_unit (
    .clk       (clk),
    .ucmd      (ucmd),
    .pos       (pos),
    .rng_end   (rng_end),
    .fill_val  (fill_val),
    .rd_data   (ram_rdata),
    .addr      (u_addr),
    .wr_data   (u_wr_data),
    .bit_value (u_bit),
    .ustat     (ustat)
  );

  // bitmap words
  bsrf_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

endmodule
